// ===== hw/rtl/atbs_pkg.sv =====
// Package with the widths, constants and types of the adaptive threshold bit slicer.
`timescale 1ns / 1ps

package atbs_pkg;

  localparam int AdcBits   = 10;
  localparam int SampleW   = 10;
  localparam int SumW      = 16;
  localparam int LevelW    = 16;
  localparam int SprW      = 7;
  localparam int RpbW      = 10;
  localparam int ByteW     = 8;
  localparam int SlotW     = 3;
  localparam int ThreshW   = 10;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 10;
  localparam int DivCntW   = $clog2(SumW);

  localparam logic [SampleW-1:0] AdcMax  = SampleW'((1 << AdcBits) - 1);
  localparam logic [SumW-1:0]    SumMax  = 16'hffff;
  localparam logic [SlotW-1:0]   SlotTop = 3'd7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SLICE_MODE          = 2'd0,
    CFG_SAMPLES_PER_READING = 2'd1,
    CFG_READINGS_PER_BIT    = 2'd2,
    CFG_MSB_FIRST           = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_TRACK,
    ST_FINISH
  } seq_state_t;

endpackage

// ===== hw/rtl/adaptive_threshold_bit_slicer_top.sv =====
// Top level: sample averaging sequencer, level tracking and bit slicing.
// A sample that does not close a reading is accepted without a stall, back to back.
// A closing sample loads the serial divider, which runs 16 restoring steps; the sequencer
// then collects the quotient, tracks levels and, when a result is due, writes it out.
// Input is stalled throughout, and for longer while an older result is stalled.
// Synchronous active-low reset restores control and tracking state, not data registers.
`timescale 1ns / 1ps

module adaptive_threshold_bit_slicer_top
  import atbs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SampleW-1:0]  in_adc_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ByteW-1:0]    out_byte,
  output logic [ThreshW-1:0]  out_threshold,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  seq_state_t        state_r, state_nxt;
  logic              mode_r, mode_nxt;
  logic [SprW-1:0]   spr_r, spr_nxt;
  logic [RpbW-1:0]   rpb_r, rpb_nxt;
  logic              msb_r, msb_nxt;
  logic [SumW-1:0]   sum_r, sum_nxt;
  logic [SprW-1:0]   scnt_r, scnt_nxt;
  logic [RpbW-1:0]   rcnt_r, rcnt_nxt;
  logic [SlotW-1:0]  slot_r, slot_nxt;
  logic [LevelW-1:0] min_r, min_nxt;
  logic [LevelW-1:0] max_r, max_nxt;
  logic [LevelW-1:0] cut_r, cut_nxt;
  logic [ByteW-1:0]  shift_r, shift_nxt;
  logic [ByteW-1:0]  asm_r, asm_nxt;
  logic [LevelW-1:0] rd_r, rd_nxt;
  logic              ovld_r, ovld_nxt;
  logic [ByteW-1:0]  obyte_r, obyte_nxt;
  logic [ThreshW-1:0] othr_r, othr_nxt;

  logic              div_start;
  logic              div_done;
  logic [SumW-1:0]   div_quo;
  logic [SumW-1:0]   div_dividend;

  logic [SumW:0]     sum_add;
  logic [SumW-1:0]   sum_sat;
  logic [SprW-1:0]   scnt_inc;
  logic [SprW-1:0]   n_eff;
  logic [RpbW-1:0]   rcnt_inc;
  logic [RpbW-1:0]   per_bit;
  logic [SlotW-1:0]  pos;
  logic [LevelW:0]   mid_sum;
  logic [LevelW-1:0] cut_new;
  logic              out_free;

  always_comb begin
    sum_add  = {1'b0, sum_r} + (SumW + 1)'(in_adc_sample & AdcMax);
    sum_sat  = sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
    scnt_inc = scnt_r + 1'b1;
    n_eff    = (spr_r == '0) ? SprW'(1) : spr_r;
    rcnt_inc = rcnt_r + 1'b1;
    per_bit  = (rpb_r == '0) ? RpbW'(1) : rpb_r;
    pos      = msb_r ? slot_r : ~slot_r;
    mid_sum  = {1'b0, max_r} + {1'b0, min_r};
    cut_new  = (max_r > min_r) ? mid_sum[LevelW:1] : cut_r;
    out_free = !ovld_r || !out_stall;
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    spr_nxt        = spr_r;
    rpb_nxt        = rpb_r;
    msb_nxt        = msb_r;
    sum_nxt        = sum_r;
    scnt_nxt       = scnt_r;
    rcnt_nxt       = rcnt_r;
    slot_nxt       = slot_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    cut_nxt        = cut_r;
    shift_nxt      = shift_r;
    asm_nxt        = asm_r;
    rd_nxt         = rd_r;
    ovld_nxt       = ovld_r && out_stall;
    obyte_nxt      = obyte_r;
    othr_nxt       = othr_r;
    div_start      = 1'b0;
    div_dividend   = sum_sat;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLICE_MODE:          mode_nxt = cfg_wdata[0];
        CFG_SAMPLES_PER_READING: spr_nxt  = cfg_wdata[SprW-1:0];
        CFG_READINGS_PER_BIT:    rpb_nxt  = cfg_wdata[RpbW-1:0];
        CFG_MSB_FIRST:           msb_nxt  = cfg_wdata[0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (scnt_inc != '0 && scnt_inc < n_eff) begin
            sum_nxt  = sum_sat;
            scnt_nxt = scnt_inc;
          end else begin
            sum_nxt        = '0;
            scnt_nxt       = '0;
            div_start      = 1'b1;
            state_nxt      = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          rd_nxt    = div_quo;
          state_nxt = ST_TRACK;
        end
      end
      ST_TRACK: begin
        if (rd_r < min_r) min_nxt = rd_r;
        if (rd_r > max_r) max_nxt = rd_r;
        if (!mode_r) begin
          state_nxt = ST_FINISH;
        end else begin
          if (rd_r >= cut_r) asm_nxt = asm_r | (ByteW'(1) << pos);
          state_nxt = ST_IDLE;
          if (rcnt_inc != '0 && rcnt_inc < per_bit) begin
            rcnt_nxt = rcnt_inc;
          end else begin
            rcnt_nxt = '0;
            if (slot_r != '0) begin
              slot_nxt = slot_r - 1'b1;
            end else begin
              state_nxt = ST_FINISH;
            end
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cut_nxt  = cut_new;
          othr_nxt = cut_new[ThreshW-1:0];
          ovld_nxt = 1'b1;
          if (!mode_r) begin
            shift_nxt = {shift_r[ByteW-2:0], (rd_r >= cut_new)};
            obyte_nxt = {shift_r[ByteW-2:0], (rd_r >= cut_new)};
          end else begin
            obyte_nxt = asm_r;
            asm_nxt   = '0;
            slot_nxt  = SlotTop;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  atbs_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (n_eff),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= 1'b1;
      spr_r   <= SprW'(10);
      rpb_r   <= RpbW'(10);
      msb_r   <= 1'b1;
      sum_r   <= '0;
      scnt_r  <= '0;
      rcnt_r  <= '0;
      slot_r  <= SlotTop;
      min_r   <= LevelW'(AdcMax);
      max_r   <= LevelW'(1);
      cut_r   <= '0;
      shift_r <= '0;
      asm_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      spr_r   <= spr_nxt;
      rpb_r   <= rpb_nxt;
      msb_r   <= msb_nxt;
      sum_r   <= sum_nxt;
      scnt_r  <= scnt_nxt;
      rcnt_r  <= rcnt_nxt;
      slot_r  <= slot_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      cut_r   <= cut_nxt;
      shift_r <= shift_nxt;
      asm_r   <= asm_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r    <= rd_nxt;
    obyte_r <= obyte_nxt;
    othr_r  <= othr_nxt;
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = ovld_r;
  assign out_byte      = obyte_r;
  assign out_threshold = othr_r;

endmodule

// ===== hw/rtl/atbs_divider.sv =====
// Bit-serial restoring divider that turns a sample sum into one averaged reading.
`timescale 1ns / 1ps

module atbs_divider
  import atbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SumW-1:0]  dividend,
  input  logic [SprW-1:0]  divisor,
  output logic             done,
  output logic [SumW-1:0]  quotient
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic [SumW-1:0]    quo_r, quo_nxt;
  logic [SprW-1:0]    rem_r, rem_nxt;
  logic [SprW-1:0]    dvs_r, dvs_nxt;
  logic [SprW:0]      rem_shift;
  logic [SprW:0]      rem_diff;

  always_comb begin
    rem_shift = {rem_r, quo_r[SumW-1]};
    rem_diff  = rem_shift - {1'b0, dvs_r};
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (rem_shift >= {1'b0, dvs_r}) begin
        rem_nxt = rem_diff[SprW-1:0];
        quo_nxt = {quo_r[SumW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_shift[SprW-1:0];
        quo_nxt = {quo_r[SumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DivCntW'(SumW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the adaptive threshold bit slicer with directed and random samples.
`timescale 1ns / 1ps

module testbench
  import atbs_pkg::*;
;

  localparam int CycleLimit    = 600000;
  localparam int SettleCycles  = 24;
  localparam int DrainLimit    = 20000;
  localparam int TargetSamples = 1950;
  localparam int TargetBytes   = 48;
  localparam int LateStart     = 1700;

  typedef struct {
    logic [ByteW-1:0]   bits;
    logic [ThreshW-1:0] level;
  } slice_result_t;

  typedef struct {
    bit                  is_cfg;
    cfg_reg_t            index;
    logic [CfgDataW-1:0] value;
    bit                  typed;
    logic [ByteW-1:0]    bits;
    logic [ThreshW-1:0]  level;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SampleW-1:0]  in_adc_sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ByteW-1:0]    out_byte;
  logic [ThreshW-1:0]  out_threshold;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  logic                mode_q = 1'b1;
  logic [SprW-1:0]     spr_q = 7'd10;
  logic [RpbW-1:0]     rpb_q = 10'd10;
  logic                msb_q = 1'b1;
  logic [SumW-1:0]     acc_sum = '0;
  logic [SprW-1:0]     acc_count = '0;
  logic [RpbW-1:0]     reading_count = '0;
  logic [SlotW-1:0]    slot = SlotTop;
  logic [LevelW-1:0]   level_min = LevelW'(AdcMax);
  logic [LevelW-1:0]   level_max = LevelW'(1);
  logic [LevelW-1:0]   cutout = '0;
  logic [ByteW-1:0]    shift_reg = '0;
  logic [ByteW-1:0]    byte_acc = '0;

  slice_result_t pending_slices[$];
  int            mismatch_count = 0;
  int            samples_sent = 0;
  int            bytes_due = 0;
  int            bytes_seen = 0;
  int            settings_used = 0;
  int            cycle_count = 0;
  int            gap_pct = 36;
  int            stall_pct = 67;

  stim_row_t dir_rows [34] = '{
    '{1'b1, CFG_SLICE_MODE,          10'd0,    1'b0, 8'h00, 10'd0},
    '{1'b1, CFG_SAMPLES_PER_READING, 10'd1,    1'b0, 8'h00, 10'd0},
    '{1'b1, CFG_READINGS_PER_BIT,    10'd1,    1'b0, 8'h00, 10'd0},
    '{1'b1, CFG_MSB_FIRST,           10'd1,    1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd300,  1'b1, 8'h01, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd200,  1'b1, 8'h02, 10'd250},
    '{1'b0, CFG_SLICE_MODE,          10'd600,  1'b1, 8'h05, 10'd400},
    '{1'b0, CFG_SLICE_MODE,          10'd399,  1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd400,  1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd1023, 1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd0,    1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd511,  1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd510,  1'b0, 8'h00, 10'd0},
    '{1'b1, CFG_SAMPLES_PER_READING, 10'd0,    1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd1023, 1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd5,    1'b0, 8'h00, 10'd0},
    '{1'b1, CFG_SLICE_MODE,          10'd1,    1'b0, 8'h00, 10'd0},
    '{1'b1, CFG_READINGS_PER_BIT,    10'd0,    1'b0, 8'h00, 10'd0},
    '{1'b1, CFG_MSB_FIRST,           10'd0,    1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd1023, 1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd0,    1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd1023, 1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd0,    1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd600,  1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd0,    1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd0,    1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd1023, 1'b0, 8'h00, 10'd0},
    '{1'b1, CFG_MSB_FIRST,           10'd1,    1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd0,    1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd1023, 1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd1023, 1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd0,    1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd1023, 1'b0, 8'h00, 10'd0},
    '{1'b0, CFG_SLICE_MODE,          10'd700,  1'b0, 8'h00, 10'd0}
  };

  adaptive_threshold_bit_slicer_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_adc_sample(in_adc_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_threshold(out_threshold),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void refresh_cutout();
    logic [LevelW:0] span;
    if (level_max > level_min) begin
      span = level_min + level_max;
      cutout = span[LevelW:1];
    end
  endfunction

  function automatic bit slice_predict(input logic [SampleW-1:0] sample,
                                       output slice_result_t res);
    logic [SumW:0]   total;
    logic [SumW-1:0] reading;
    logic [SprW-1:0] group;
    logic [RpbW-1:0] per_slot;
    res = '{default: '0};
    group = (spr_q == '0) ? SprW'(1) : spr_q;
    per_slot = (rpb_q == '0) ? RpbW'(1) : rpb_q;
    total = acc_sum + sample;
    acc_sum = (total > SumMax) ? SumMax : total[SumW-1:0];
    acc_count = acc_count + 1'b1;
    if (acc_count != '0 && acc_count < group) return 0;
    reading = acc_sum / group;
    acc_sum = '0;
    acc_count = '0;
    if (reading < level_min) level_min = reading;
    if (reading > level_max) level_max = reading;
    if (!mode_q) begin
      refresh_cutout();
      shift_reg = {shift_reg[ByteW-2:0], reading >= cutout};
      res.bits = shift_reg;
      res.level = cutout[ThreshW-1:0];
      return 1;
    end
    if (reading >= cutout) byte_acc[msb_q ? slot : SlotTop - slot] = 1'b1;
    reading_count = reading_count + 1'b1;
    if (reading_count != '0 && reading_count < per_slot) return 0;
    reading_count = '0;
    if (slot != '0) begin
      slot = slot - 1'b1;
      return 0;
    end
    refresh_cutout();
    res.bits = byte_acc;
    res.level = cutout[ThreshW-1:0];
    byte_acc = '0;
    slot = SlotTop;
    return 1;
  endfunction

  function automatic logic [SampleW-1:0] pick_sample(input bit high_only);
    int unsigned centre;
    centre = (cutout > 16'd1020) ? 1020 : int'(cutout);
    if (high_only) return SampleW'($urandom_range(900, 1023));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SampleW'($urandom_range(0, 1023));
      4, 5: return SampleW'($urandom_range(0, 127));
      6, 7: return SampleW'($urandom_range(896, 1023));
      default: return SampleW'($urandom_range((centre > 3) ? centre - 3 : 0, centre + 3));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at cycle %0d, %s: got 0x%0h, expected 0x%0h",
             cycle_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic write_reg(input cfg_reg_t index, input logic [CfgDataW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    case (index)
      CFG_SLICE_MODE:          mode_q = value[0];
      CFG_SAMPLES_PER_READING: spr_q = value[SprW-1:0];
      CFG_READINGS_PER_BIT:    rpb_q = value[RpbW-1:0];
      CFG_MSB_FIRST:           msb_q = value[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_settle();
    in_valid <= 1'b0;
    while (pending_slices.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic send_sample(input logic [SampleW-1:0] sample, input bit typed,
                             input slice_result_t typed_res);
    slice_result_t res;
    int gap = 0;
    if (samples_sent < 650) begin
      gap_pct = 36;
      stall_pct = 67;
    end else if (samples_sent < 1300) begin
      gap_pct = 67;
      stall_pct = 36;
    end else begin
      gap_pct = 0;
      stall_pct = 0;
    end
    while ($urandom_range(0, 99) < gap_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      in_adc_sample <= SampleW'($urandom);
      repeat (gap) @(negedge clk);
    end
    if (slice_predict(sample, res)) begin
      pending_slices.push_back(typed ? typed_res : res);
      bytes_due++;
    end
    in_valid <= 1'b1;
    in_adc_sample <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin : check_output
    slice_result_t head;
    if (rst_n && out_valid && !out_stall) begin
      bytes_seen++;
      if (pending_slices.size() == 0) begin
        report_mismatch("result with nothing outstanding", int'(out_byte), 0);
      end else begin
        head = pending_slices.pop_front();
        if (out_byte !== head.bits)
          report_mismatch("out_byte", int'(out_byte), int'(head.bits));
        if (out_threshold !== head.level)
          report_mismatch("out_threshold", int'(out_threshold), int'(head.level));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, pending_slices.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int            phase_kind;
    int            ph_len;
    int            drain;
    bit            ph_high;
    logic          ph_mode;
    logic          ph_msb;
    logic [SprW-1:0] ph_spr;
    logic [RpbW-1:0] ph_rpb;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_settle();
        write_reg(dir_rows[i].index, dir_rows[i].value);
        cfg_we <= 1'b0;
      end else begin
        send_sample(dir_rows[i].value[SampleW-1:0], dir_rows[i].typed,
                    '{dir_rows[i].bits, dir_rows[i].level});
      end
    end

    while (samples_sent < TargetSamples || bytes_due < TargetBytes) begin
      phase_kind = $urandom_range(0, 9);
      ph_high = 1'b0;
      ph_msb = 1'($urandom_range(0, 1));
      case (phase_kind)
        0: begin
          ph_mode = 1'($urandom_range(0, 1));
          ph_spr = $urandom_range(0, 1) ? 7'd127 : 7'd64;
          ph_rpb = RpbW'($urandom_range(0, 3));
          ph_len = ph_spr * $urandom_range(1, 2);
          ph_high = (ph_spr == 7'd127);
        end
        1: begin
          ph_mode = 1'b1;
          ph_spr = SprW'($urandom_range(0, 1));
          ph_rpb = 10'd1023;
          ph_len = $urandom_range(10, 60);
        end
        2, 3, 4, 5: begin
          ph_mode = 1'b0;
          ph_spr = SprW'($urandom_range(0, 4));
          ph_rpb = RpbW'($urandom_range(0, 1023));
          ph_len = $urandom_range(20, 100);
        end
        default: begin
          ph_mode = 1'b1;
          ph_spr = SprW'($urandom_range(0, 2));
          ph_rpb = RpbW'($urandom_range(0, 3));
          ph_len = $urandom_range(30, 150);
        end
      endcase

      wait_settle();
      write_reg(CFG_SLICE_MODE, {9'($urandom), ph_mode});
      write_reg(CFG_SAMPLES_PER_READING, {3'($urandom), ph_spr});
      write_reg(CFG_READINGS_PER_BIT, ph_rpb);
      write_reg(CFG_MSB_FIRST, {9'($urandom), ph_msb});
      cfg_we <= 1'b0;
      settings_used++;

      repeat (ph_len) send_sample(pick_sample(ph_high), 1'b0, '{default: '0});
      // Early settings close every group so that a shorter group cannot inflate a reading.
      if (samples_sent < LateStart)
        while (acc_count != '0) send_sample(pick_sample(ph_high), 1'b0, '{default: '0});
    end

    in_valid <= 1'b0;
    drain = 0;
    while (pending_slices.size() != 0 && drain < DrainLimit) begin
      @(posedge clk);
      drain++;
    end
    repeat (SettleCycles) @(posedge clk);
    if (pending_slices.size() != 0)
      report_mismatch("results never delivered", 0, pending_slices.size());

    $display("Fed %0d samples over %0d random register settings after the directed rows.",
             samples_sent, settings_used);
    $display("Checked %0d of %0d predicted results; %0d mismatches.",
             bytes_seen, bytes_due, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
